>>> hdl/qsn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsn_pkg: shared constants and types for the q15 square root block
// widths of the radicand, estimate and product words, the Newton constants,
// and the normalizer result type
// ----------------------------------------------------------------------------
package qsn_pkg;

   localparam int VALUE_W   = 15;   // q15 radicand
   localparam int ROOT_W    = 16;   // result fields
   localparam int COUNT_W   = 6;    // iteration count
   localparam int EST_W     = 18;   // q14 estimate, always below 2^18
   localparam int PROD_W    = 32;   // all arithmetic is modulo 2^32
   localparam int SHIFT_W   = 3;    // down shift, at most 6
   localparam int UP_W      = 4;    // up shift, at most 12
   localparam int BIT_W     = 4;    // top bit position, 0 to 15

   localparam int IN_FRAC      = 15;
   localparam int EST_FRAC     = 14;
   localparam int EST_ONE_HALF = 24576;
   localparam int UP_MASK      = 'h0fe;

   localparam int MAX_ITERATIONS_DEFAULT = 50;

   typedef struct packed {
      logic [VALUE_W-1:0] num;
      logic [SHIFT_W-1:0] down;
   } norm_type;

endpackage
`default_nettype wire

>>> hdl/q15_sqrt_newton_inverse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q15_sqrt_newton_inverse: q15 square root by newton iteration on 1/sqrt
// normalizes the radicand, iterates the q14 inverse root estimate on one
// shared registered multiplier until stable or at the limit, then scales back
// ----------------------------------------------------------------------------
//  channel  ports                                             direction
//  req      req_valid, req_stall, req_value                   in
//  rsp      rsp_valid, rsp_stall, rsp_root, rsp_inverse_root,
//           rsp_iteration_count                               out
//
//  an item goes from transfer through S_SQ, then n newton steps of S_TN, S_XT
//  and S_UPD (n from 1 to MAX_ITERATIONS), then S_OUT, which waits on rsp_stall
//  each step is three dependent products on the single shared multiplier
//  req_stall is high while an item is in work; a new item is taken while a
//  finished result still waits in the output register
//  reset is synchronous and clears the sequencer and the output valid
// ----------------------------------------------------------------------------
module q15_sqrt_newton_inverse #(
   parameter int MAX_ITERATIONS = qsn_pkg::MAX_ITERATIONS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [qsn_pkg::VALUE_W-1:0]   req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [qsn_pkg::ROOT_W-1:0]    rsp_root,
   output logic      [qsn_pkg::ROOT_W-1:0]    rsp_inverse_root,
   output logic      [qsn_pkg::COUNT_W-1:0]   rsp_iteration_count
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQ   = 3'd1;   // issue x*x
   localparam logic [2:0] S_TN   = 3'd2;   // issue (x*x >> 14) * num
   localparam logic [2:0] S_XT   = 3'd3;   // issue x * (1.5 - t/2), t = x*x*num
   localparam logic [2:0] S_UPD  = 3'd4;   // new estimate, check convergence
   localparam logic [2:0] S_OUT  = 3'd5;   // final x*num, scale and load

   localparam int E = qsn_pkg::EST_W;
   localparam int P = qsn_pkg::PROD_W;

   logic [2:0]                    state_ff, state_in;
   logic [qsn_pkg::VALUE_W-1:0]   num_ff, num_in;
   logic [qsn_pkg::SHIFT_W-1:0]   down_ff, down_in;
   logic [E-1:0]                  x_ff, x_in;
   logic [qsn_pkg::COUNT_W-1:0]   it_ff, it_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [qsn_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic [qsn_pkg::ROOT_W-1:0]    inv_ff, inv_in;
   logic [qsn_pkg::COUNT_W-1:0]   count_ff, count_in;

   qsn_pkg::norm_type             norm;
   logic [E-1:0]                  mul_a;
   logic [P-1:0]                  mul_b;
   logic [P-1:0]                  product;

   logic                          req_xfer;
   logic                          load_out;
   logic [E-1:0]                  x_new;
   logic [P-1:0]                  t_half;
   logic                          converged;
   logic                          at_limit;
   logic [P-1:0]                  root_wide;

   qsn_norm u_norm (
      .value  (req_value),
      .result (norm)
   );

   qsn_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign load_out  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign x_new     = product[P-1:qsn_pkg::EST_FRAC];
   assign t_half    = P'(qsn_pkg::EST_ONE_HALF) - P'(product[P-1:qsn_pkg::IN_FRAC+1]);
   assign converged = (x_new == x_ff);
   assign at_limit  = (it_ff == qsn_pkg::COUNT_W'(MAX_ITERATIONS - 1));
   assign root_wide = product >> (5'(qsn_pkg::EST_FRAC) + 5'(down_ff));

   // operand select for the shared multiplier
   always_comb begin
      mul_a = x_ff;
      mul_b = P'(num_ff);
      unique case (state_ff)
         S_SQ: begin
            mul_b = P'(x_ff);
         end
         S_TN: begin
            mul_a = product[P-1:qsn_pkg::EST_FRAC];
         end
         S_XT: begin
            mul_b = t_half;
         end
         S_UPD: begin
            mul_a = x_new;
            mul_b = (converged || at_limit) ? P'(num_ff) : P'(x_new);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      down_in  = down_ff;
      x_in     = x_ff;
      it_in    = it_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               num_in   = norm.num;
               down_in  = norm.down;
               x_in     = E'(norm.num >> 2) + E'(1);
               it_in    = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            state_in = S_TN;
         end
         S_TN: begin
            state_in = S_XT;
         end
         S_XT: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            x_in = x_new;
            if (converged) begin
               state_in = S_OUT;
            end else begin
               it_in    = it_ff + 1'b1;
               state_in = at_limit ? S_OUT : S_TN;
            end
         end
         S_OUT: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      root_in      = root_ff;
      inv_in       = inv_ff;
      count_in     = count_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         root_in      = (root_wide[P-1:qsn_pkg::ROOT_W] != '0) ? '1
                        : root_wide[qsn_pkg::ROOT_W-1:0];
         inv_in       = qsn_pkg::ROOT_W'(x_ff);
         count_in     = it_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      down_ff  <= down_in;
      x_ff     <= x_in;
      it_ff    <= it_in;
      root_ff  <= root_in;
      inv_ff   <= inv_in;
      count_ff <= count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_root            = root_ff;
   assign rsp_inverse_root    = inv_ff;
   assign rsp_iteration_count = count_ff;

   // a new result only appears out of the final scaling state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result loaded outside final state");

   // an accepted item always starts the first square
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == S_SQ)
      else $error("accepted item did not start iteration");

   // the step counter stays below the limit while stepping
   a_it_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TN || state_ff == S_XT || state_ff == S_UPD)
      |-> it_ff < qsn_pkg::COUNT_W'(MAX_ITERATIONS))
      else $error("iteration counter past limit");

   // a delivered count never exceeds the limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> count_ff <= qsn_pkg::COUNT_W'(MAX_ITERATIONS))
      else $error("result count past limit");

endmodule
`default_nettype wire

>>> hdl/qsn_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsn_norm: radicand normalizer
// finds the highest set bit (zero counts as bit 15) and shifts the radicand
// up by an even amount when that bit is 13 or lower
// ----------------------------------------------------------------------------
module qsn_norm (
   input  wire logic [qsn_pkg::VALUE_W-1:0] value,
   output qsn_pkg::norm_type                result
);

   logic [qsn_pkg::BIT_W-1:0] top_bit;
   logic [qsn_pkg::UP_W-1:0]  up;

   always_comb begin
      top_bit = qsn_pkg::BIT_W'(qsn_pkg::IN_FRAC);
      for (int i = 0; i < qsn_pkg::VALUE_W; i++) begin
         if (value[i]) begin
            top_bit = qsn_pkg::BIT_W'(i);
         end
      end
   end

   always_comb begin
      up = '0;
      if ((5'(top_bit) + 5'd2) <= 5'(qsn_pkg::IN_FRAC)) begin
         up = qsn_pkg::UP_W'(5'(qsn_pkg::IN_FRAC) - 5'(top_bit) - 5'd2)
              & qsn_pkg::UP_W'(qsn_pkg::UP_MASK);
      end
      result.num  = value << up;
      result.down = qsn_pkg::SHIFT_W'(up >> 1);
   end

endmodule
`default_nettype wire

>>> hdl/qsn_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsn_mul: shared multiplier
// estimate-wide by word-wide product, low 32 bits kept, registered output
// ----------------------------------------------------------------------------
module qsn_mul (
   input  wire logic                        clock,
   input  wire logic [qsn_pkg::EST_W-1:0]   op_a,
   input  wire logic [qsn_pkg::PROD_W-1:0]  op_b,
   output logic      [qsn_pkg::PROD_W-1:0]  product
);

   logic [qsn_pkg::PROD_W-1:0] product_ff;
   logic [qsn_pkg::PROD_W-1:0] product_in;

   // only the low word of the product is ever needed
   assign product_in = qsn_pkg::PROD_W'(op_a) * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule
`default_nettype wire
